/* rtl/mpq_pkg.sv */
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [63:0] key_t;

  localparam logic [1:0] REQ_INSERT   = 2'd0;
  localparam logic [1:0] REQ_EXTRACT  = 2'd1;
  localparam logic [1:0] REQ_DECREASE = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_EMPTY   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    key_t       key;
    key_t       new_key;
  } req_t;

  typedef struct packed {
    key_t       min_value;
    logic [1:0] status;
    logic [6:0] count_after;
  } res_t;

  // command from the sequencer to every cell of the row
  typedef struct packed {
    logic load;  // take compare flags for the incoming word
    logic ins;
    logic ext;
    logic dec;
  } cmd_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic valid;
    key_t value;
    logic gt_key;  // holds a key greater than the request key
    logic gt_new;  // holds a key greater than the new key
    logic lt_key;  // holds a key less than the request key
    logic match;   // holds a key equal to the request key
  } cell_t;

endpackage

/* rtl/mpq_cell.sv */
module mpq_cell (
  input  logic          clk,
  input  logic          rst,
  input  mpq_pkg::cmd_t cmd,
  input  mpq_pkg::key_t key_in,
  input  mpq_pkg::key_t new_in,
  input  mpq_pkg::key_t key_q,
  input  mpq_pkg::key_t new_q,
  input  mpq_pkg::cell_t prev,
  input  mpq_pkg::cell_t next,
  output mpq_pkg::cell_t self
);
  import mpq_pkg::*;

  logic valid;
  key_t value;
  logic gt_key;
  logic gt_new;
  logic lt_key;
  logic match;

  // compare flags are taken in the cycle the word is accepted
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      gt_key <= valid && ($signed(key_in) < $signed(value));
      gt_new <= valid && ($signed(new_in) < $signed(value));
      lt_key <= valid && ($signed(value) < $signed(key_in));
      match  <= valid && (value == key_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (cmd.ins) begin
        // shift right behind the insertion point, new key lands at the gap
        if (prev.gt_key) begin
          value <= prev.value;
          valid <= prev.valid;
        end else if (gt_key || (!valid && prev.valid)) begin
          value <= key_q;
          valid <= 1'b1;
        end
      end
      if (cmd.ext) begin
        value <= next.value;
        valid <= next.valid;
      end
      // window from the new key's place up to the first matching cell
      if (cmd.dec && prev.lt_key && gt_new) begin
        value <= prev.gt_new ? prev.value : new_q;
      end
    end
  end

  assign self = '{valid: valid, value: value, gt_key: gt_key, gt_new: gt_new,
                  lt_key: lt_key, match: match};

endmodule

/* rtl/min_priority_queue_decrease_key.sv */
// a word's flags are compared and registered as it is accepted, the sorted
// cell row shifts in the apply state, and done is registered after that
// a new word is taken once the apply state is over, as busy is high only there;
// the receiver cannot stall results
// reset: synchronous, empties the row and clears the count
module min_priority_queue_decrease_key (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  mpq_pkg::req_t req,
  output logic          done,
  output mpq_pkg::res_t res
);
  import mpq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [1:0]       req_type_q;
  key_t             key_q;
  key_t             new_q;
  logic             less_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  res_t             res_next;

  cmd_t  cmd;
  cell_t links [CAPACITY];
  cell_t head_bound;
  cell_t tail_bound;
  logic [CAPACITY-1:0] match_vec;
  logic found;
  logic accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  assign head_bound = '{valid: 1'b1, value: '0, gt_key: 1'b0, gt_new: 1'b0,
                        lt_key: 1'b1, match: 1'b0};
  assign tail_bound = '{valid: 1'b0, value: '0, gt_key: 1'b0, gt_new: 1'b0,
                        lt_key: 1'b0, match: 1'b0};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_row
      cell_t prev_link;
      cell_t next_link;
      if (gi == 0) begin : g_head
        assign prev_link = head_bound;
      end else begin : g_mid
        assign prev_link = links[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign next_link = tail_bound;
      end else begin : g_body
        assign next_link = links[gi+1];
      end
      mpq_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .cmd    (cmd),
        .key_in (req.key),
        .new_in (req.new_key),
        .key_q  (key_q),
        .new_q  (new_q),
        .prev   (prev_link),
        .next   (next_link),
        .self   (links[gi])
      );
      assign match_vec[gi] = links[gi].match;
    end
  endgenerate

  assign found = |match_vec;

  always_comb begin
    cmd.load = accept;
    cmd.ins  = (state == ST_APPLY) && (req_type_q == REQ_INSERT) &&
               (count != CNT_W'(CAPACITY));
    cmd.ext  = (state == ST_APPLY) && (req_type_q == REQ_EXTRACT) && links[0].valid;
    cmd.dec  = (state == ST_APPLY) && (req_type_q == REQ_DECREASE) && less_q && found;
  end

  always_comb begin
    count_next = count;
    res_next   = '{min_value: '0, status: STAT_IGNORED, count_after: '0};
    unique case (req_type_q)
      REQ_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          res_next.status = STAT_FULL;
        end else begin
          count_next      = count + CNT_W'(1);
          res_next.status = STAT_DONE;
        end
      end
      REQ_EXTRACT: begin
        if (links[0].valid) begin
          count_next         = count - CNT_W'(1);
          res_next.min_value = links[0].value;
          res_next.status    = STAT_DONE;
        end else begin
          res_next.status = STAT_EMPTY;
        end
      end
      REQ_DECREASE: begin
        res_next.status = (less_q && found) ? STAT_DONE : STAT_IGNORED;
      end
      default: begin
        res_next.status = STAT_IGNORED;
      end
    endcase
    res_next.count_after = 7'(count_next);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type_q <= req.req_type;
      key_q      <= req.key;
      new_q      <= req.new_key;
      less_q     <= ($signed(req.new_key) < $signed(req.key));
    end
    if (state == ST_APPLY) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_APPLY);
      if (state == ST_APPLY) begin
        count <= count_next;
      end
    end
  end

  // the result word comes in the cycle after the shift cycle
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |=> done)
    else $error("result word missing after shift cycle");

  a_done_only_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_APPLY))
    else $error("result word without a shift cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !links[0].valid)
    else $error("head cell disagrees with stored count");

endmodule

/* bench/min_priority_queue_decrease_key_tb.sv */
`timescale 1ns / 1ps

module min_priority_queue_decrease_key_tb;
  import mpq_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam key_t KEY_MAX = key_t'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam key_t KEY_MIN = key_t'(64'h8000_0000_0000_0000);

  // tracks the queue contents and the results the block owes
  class mpq_scoreboard;
    key_t slot_key[CAPACITY];
    bit slot_used[CAPACITY];
    int depth;
    res_t expected[$];
    int errors;
    int words;
    int fulls;
    int empties;
    int lowered;
    int ignored;
    int peak;

    function void note_request(req_t r);
      res_t e;
      key_t old_key;
      key_t low_key;
      int best;
      e.min_value = '0;
      e.status = STAT_IGNORED;
      old_key = r.key;
      low_key = r.new_key;
      best = -1;
      case (r.req_type)
        REQ_INSERT: begin
          if (depth >= CAPACITY) begin
            e.status = STAT_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (!slot_used[i] && best < 0) best = i;
            end
            slot_key[best] = old_key;
            slot_used[best] = 1'b1;
            depth++;
            e.status = STAT_DONE;
          end
        end
        REQ_EXTRACT: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (slot_used[i] && (best < 0 || slot_key[i] < slot_key[best])) best = i;
          end
          if (best < 0) begin
            e.status = STAT_EMPTY;
          end else begin
            e.min_value = slot_key[best];
            slot_used[best] = 1'b0;
            depth--;
            e.status = STAT_DONE;
          end
        end
        REQ_DECREASE: begin
          if (low_key < old_key) begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (slot_used[i] && slot_key[i] == old_key && best < 0) best = i;
            end
            if (best >= 0) begin
              slot_key[best] = low_key;
              e.status = STAT_DONE;
            end
          end
        end
        default: ;
      endcase
      e.count_after = 7'(depth);
      expected = {expected, e};
      words++;
      if (depth > peak) peak = depth;
      case (e.status)
        STAT_FULL: fulls++;
        STAT_EMPTY: empties++;
        STAT_IGNORED: ignored++;
        default: if (r.req_type == REQ_DECREASE) lowered++;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected.size() == 0) begin
        $error("result with nothing outstanding: min_value %0d status %0d count_after %0d",
               got.min_value, got.status, got.count_after);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (got.min_value !== e.min_value) begin
        $error("min_value: expected %0d, got %0d", e.min_value, got.min_value);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.count_after !== e.count_after) begin
        $error("count_after: expected %0d, got %0d", e.count_after, got.count_after);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // a key currently held, starting the scan at a random slot
    function bit stored_key(output key_t k);
      int s;
      s = $urandom_range(0, CAPACITY - 1);
      for (int i = 0; i < CAPACITY; i++) begin
        if (slot_used[(s + i) % CAPACITY]) begin
          k = slot_key[(s + i) % CAPACITY];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  req_t req_word = '0;
  res_t res_word;

  mpq_scoreboard sb;

  min_priority_queue_decrease_key dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req_word),
    .done(done),
    .res(res_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(res_word);
  end

  function automatic req_t make_req(logic [1:0] t, key_t a, key_t b);
    req_t r;
    r.req_type = t;
    r.key = a;
    r.new_key = b;
    return r;
  endfunction

  // many small values and extremes so that duplicates and matches are common
  function automatic key_t rand_key();
    case ($urandom_range(0, 4))
      0, 1: return key_t'({$urandom, $urandom});
      2: return key_t'($urandom_range(0, 16)) - key_t'(8);
      3: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return key_t'($urandom_range(0, 200000)) - key_t'(100000);
    endcase
  endfunction

  // start stays high straight into the next word when there is no gap
  task automatic send(input req_t r, input bit calm);
    int gap;
    start <= 1'b1;
    req_word <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(r);
    gap = 0;
    if (!calm) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8: gap = $urandom_range(1, 3);
        default: gap = $urandom_range(8, 30);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    key_t k;
    key_t nk;
    req_t r;
    int mode;
    int left;
    int pick;
    int ins_lim;
    int ext_lim;
    bit calm;
    bit found;

    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send(make_req(REQ_EXTRACT, '0, '0), 1'b0);
    send(make_req(REQ_DECREASE, key_t'(5), key_t'(1)), 1'b0);
    send(make_req(REQ_UNUSED, '1, '1), 1'b0);
    send(make_req(REQ_INSERT, KEY_MAX, '0), 1'b0);
    send(make_req(REQ_INSERT, KEY_MIN, '1), 1'b0);
    send(make_req(REQ_INSERT, '0, '0), 1'b0);
    send(make_req(REQ_INSERT, '1, '0), 1'b0);
    send(make_req(REQ_INSERT, key_t'(5), '0), 1'b0);
    send(make_req(REQ_INSERT, key_t'(5), '0), 1'b0);
    // new value equal, then larger: both left alone
    send(make_req(REQ_DECREASE, key_t'(5), key_t'(5)), 1'b0);
    send(make_req(REQ_DECREASE, key_t'(5), key_t'(7)), 1'b0);
    send(make_req(REQ_DECREASE, key_t'(5), -key_t'(3)), 1'b0);
    send(make_req(REQ_DECREASE, key_t'(42), key_t'(1)), 1'b0);
    send(make_req(REQ_DECREASE, KEY_MAX, KEY_MIN), 1'b0);
    send(make_req(REQ_DECREASE, KEY_MIN, KEY_MAX), 1'b0);
    repeat (7) send(make_req(REQ_EXTRACT, '0, '0), 1'b0);

    // phases lean toward filling, draining or a mix so full and empty both occur
    left = 0;
    mode = 0;
    calm = 1'b0;
    for (int i = 0; i < 1500; i++) begin
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(40, 150);
        calm = ($urandom_range(0, 3) == 0);
      end
      left--;
      case (mode)
        0: begin ins_lim = 72; ext_lim = 82; end
        1: begin ins_lim = 15; ext_lim = 82; end
        default: begin ins_lim = 40; ext_lim = 75; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < ins_lim) begin
        r = make_req(REQ_INSERT, rand_key(), rand_key());
      end else if (pick < ext_lim) begin
        r = make_req(REQ_EXTRACT, rand_key(), rand_key());
      end else if (pick < 97) begin
        found = 1'b0;
        if ($urandom_range(0, 3) != 0) found = sb.stored_key(k);
        if (!found) k = rand_key();
        case ($urandom_range(0, 9))
          0, 1: nk = rand_key();
          2: nk = k;
          default: nk = k - key_t'($urandom_range(1, 1000));
        endcase
        r = make_req(REQ_DECREASE, k, nk);
      end else begin
        r = make_req(REQ_UNUSED, rand_key(), rand_key());
      end
      send(r, calm);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("run covered %0d words: %0d inserts refused as full, %0d extracts on empty,",
             sb.words, sb.fulls, sb.empties);
    $display("%0d keys lowered, %0d requests ignored, peak depth %0d",
             sb.lowered, sb.ignored, sb.peak);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
